// ===== rtl/sdda_pkg.sv =====
`default_nettype none

package sdda_pkg;

    localparam int unsigned SEG_W          = 32;
    localparam int unsigned LEVEL_W        = 5;
    localparam int unsigned CFG_IDX_W      = 1;
    localparam int unsigned QUEUE_DEPTH    = 16;

    localparam logic [SEG_W-1:0] INIT_INTERVAL = 32'd2000;
    localparam logic [SEG_W-1:0] MIN_INTERVAL  = 32'd50;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL     = 1'd1;

    // word kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_PUSH = 1'b1;

    typedef struct packed {
        logic [SEG_W-1:0] rate;
        logic [SEG_W-1:0] limit;
        logic [SEG_W-1:0] steps;
        logic [SEG_W-1:0] accum_init;
        logic [SEG_W-1:0] interval;
    } t_seg;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

    typedef struct packed {
        logic step;
        logic active;
        logic dropped;
    } t_core_res;

endpackage

`default_nettype wire

// ===== rtl/segment_dda_step_generator_top.sv =====
`default_nettype none

// Segment DDA step generator. Each word is either a timebase tick (kind 0)
// or a segment push (kind 1) into a QUEUE_DEPTH-entry queue; every word gives
// exactly one result word. Throughput is one word per clock unless the output
// is stalled: an input register feeds the single-pass update of countdown,
// accumulator and queue, which loads the result register. The queue head is
// prefetched from its memory each cycle, so a pop need not wait for a read. Both
// registers hold while the output is stalled; the input side stalls only when
// both are full. Configuration writes take effect at once and are meant for
// idle periods; a write to initial_interval also reloads the alarm countdown.

module segment_dda_step_generator_top #(
    parameter int unsigned QUEUE_DEPTH = sdda_pkg::QUEUE_DEPTH
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [sdda_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [sdda_pkg::SEG_W-1:0]         i_cfg_data,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire                                i_kind,
    input  wire  [sdda_pkg::SEG_W-1:0]         i_seg_rate,
    input  wire  [sdda_pkg::SEG_W-1:0]         i_seg_limit,
    input  wire  [sdda_pkg::SEG_W-1:0]         i_seg_steps,
    input  wire  [sdda_pkg::SEG_W-1:0]         i_seg_accum_init,
    input  wire  [sdda_pkg::SEG_W-1:0]         i_seg_interval,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic                               o_step_pulse,
    output logic                               o_segment_active,
    output logic [sdda_pkg::LEVEL_W-1:0]       o_queue_level,
    output logic                               o_push_rejected,
    output logic                               o_segment_dropped
);

    localparam int unsigned LW = $clog2(QUEUE_DEPTH + 1);

    logic                  r_in_valid;
    logic                  r_in_kind;
    sdda_pkg::t_seg        r_in_seg;

    logic                  r_out_valid;
    logic                  r_step, r_active, r_rejected, r_dropped;
    logic [sdda_pkg::LEVEL_W-1:0] r_level;

    logic                  out_free, go, in_acc, push_req, tick;
    sdda_pkg::t_seg        in_seg, head;
    sdda_pkg::t_fifo_ctl   fifo_ctl;
    sdda_pkg::t_fifo_stat  fifo_stat;
    sdda_pkg::t_core_res   core_res;
    logic                  pop;
    logic [LW-1:0]         level_next;
    logic [LW+sdda_pkg::LEVEL_W-1:0] level_ext;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign go         = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign push_req   = go && (r_in_kind == sdda_pkg::KIND_PUSH);
    assign tick       = go && (r_in_kind == sdda_pkg::KIND_TICK);

    assign fifo_ctl.push = push_req && !fifo_stat.full;
    assign fifo_ctl.pop  = pop;

    assign level_ext  = {{sdda_pkg::LEVEL_W{1'b0}}, level_next};

    always_comb begin
        in_seg.rate       = i_seg_rate;
        in_seg.limit      = i_seg_limit;
        in_seg.steps      = i_seg_steps;
        in_seg.accum_init = i_seg_accum_init;
        in_seg.interval   = i_seg_interval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_kind <= i_kind;
            r_in_seg  <= in_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_step     <= core_res.step;
            r_active   <= core_res.active;
            r_dropped  <= core_res.dropped;
            r_rejected <= push_req && fifo_stat.full;
            r_level    <= level_ext[sdda_pkg::LEVEL_W-1:0];
        end
    end

    sdda_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .LW    (LW)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (fifo_ctl),
        .i_wr_seg     (r_in_seg),
        .o_head       (head),
        .o_stat       (fifo_stat),
        .o_level_next (level_next)
    );

    sdda_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tick      (tick),
        .i_head      (head),
        .i_fifo_stat (fifo_stat),
        .o_pop       (pop),
        .o_res       (core_res)
    );

    assign o_out_valid       = r_out_valid;
    assign o_step_pulse      = r_step;
    assign o_segment_active  = r_active;
    assign o_queue_level     = r_level;
    assign o_push_rejected   = r_rejected;
    assign o_segment_dropped = r_dropped;

`ifndef NO_ASSERTIONS
    // a push word never steps or pops
    a_push_no_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_push_rejected |-> !o_step_pulse && !o_segment_dropped)
        else $error("push word reported step or drop");

    // full queue rejects the push on the following result
    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_req && fifo_stat.full |=> o_out_valid && o_push_rejected)
        else $error("push into full queue not flagged");

    // held input word survives an output stall
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && i_out_stall |=> r_in_valid)
        else $error("input word lost under stall");

    // never push and pop in the same word
    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_ctl.push && fifo_ctl.pop))
        else $error("push and pop together");
`endif

endmodule

`default_nettype wire

// ===== rtl/sdda_fifo.sv =====
`default_nettype none

module sdda_fifo #(
    parameter int unsigned DEPTH = sdda_pkg::QUEUE_DEPTH,
    parameter int unsigned LW    = $clog2(DEPTH + 1)
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  sdda_pkg::t_fifo_ctl    i_ctl,
    input  sdda_pkg::t_seg         i_wr_seg,
    output sdda_pkg::t_seg         o_head,
    output sdda_pkg::t_fifo_stat   o_stat,
    output logic [LW-1:0]          o_level_next
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [LW-1:0] FULL_LVL = LW'(DEPTH);

    sdda_pkg::t_seg  r_mem [DEPTH];
    sdda_pkg::t_seg  r_head;
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [LW-1:0]   r_fill, n_fill;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_ctl.push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            n_fill   = r_fill + 1'b1;
        end
        if (i_ctl.pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            n_fill   = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // storage, head word prefetched from the next read address
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_wr_ptr] <= i_wr_seg;
        end
        if (i_ctl.push && (r_wr_ptr == n_rd_ptr)) begin
            r_head <= i_wr_seg;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

    assign o_head       = r_head;
    assign o_stat.empty = (r_fill == '0);
    assign o_stat.full  = (r_fill == FULL_LVL);
    assign o_level_next = n_fill;

endmodule

`default_nettype wire

// ===== rtl/sdda_core.sv =====
`default_nettype none

module sdda_core (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_we,
    input  wire  [sdda_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire  [sdda_pkg::SEG_W-1:0]             i_cfg_data,
    input  wire                                    i_tick,
    input  sdda_pkg::t_seg                         i_head,
    input  sdda_pkg::t_fifo_stat                   i_fifo_stat,
    output logic                                   o_pop,
    output sdda_pkg::t_core_res                    o_res
);

    localparam int unsigned W = sdda_pkg::SEG_W;

    logic [W-1:0] r_rate, r_limit, r_steps, r_accum;
    logic [W-1:0] r_interval, r_countdown, r_min_interval;

    logic         alarm, active, step, exhausted, drop, load;
    logic [W:0]   sum;
    logic [W+1:0] diff;
    logic [W-1:0] acc_new;

    always_comb begin
        alarm     = i_tick && (r_countdown <= W'(1));
        active    = (r_steps != '0);
        sum       = {1'b0, r_accum} + {1'b0, r_rate};
        diff      = {2'b00, r_accum} + {2'b00, r_rate} - {2'b00, r_limit};
        // saturated sum always clears the limit
        step      = alarm && active && (sum[W] || !diff[W+1]);
        if (sum[W]) begin
            acc_new = ~r_limit;
        end else if (step) begin
            acc_new = diff[W-1:0];
        end else begin
            acc_new = sum[W-1:0];
        end
        exhausted = !active || (step && (r_steps == W'(1)));
        o_pop     = alarm && exhausted && !i_fifo_stat.empty;
        drop      = o_pop && (i_head.interval < r_min_interval);
        load      = o_pop && !drop;

        o_res.step    = step;
        o_res.dropped = drop;
        if (load) begin
            o_res.active = (i_head.steps != '0);
        end else begin
            o_res.active = active && !(step && (r_steps == W'(1)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate         <= '0;
            r_limit        <= '0;
            r_steps        <= '0;
            r_accum        <= '0;
            r_interval     <= sdda_pkg::INIT_INTERVAL;
            r_countdown    <= sdda_pkg::INIT_INTERVAL;
            r_min_interval <= sdda_pkg::MIN_INTERVAL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sdda_pkg::CFG_INITIAL_INTERVAL: begin
                    r_interval  <= i_cfg_data;
                    r_countdown <= i_cfg_data;
                end
                sdda_pkg::CFG_MIN_INTERVAL: begin
                    r_min_interval <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end else if (i_tick) begin
            if (!alarm) begin
                r_countdown <= r_countdown - 1'b1;
            end else begin
                r_countdown <= r_interval;
                if (active) begin
                    r_accum <= acc_new;
                end
                if (step) begin
                    r_steps <= r_steps - 1'b1;
                end
                if (load) begin
                    r_rate     <= i_head.rate;
                    r_limit    <= i_head.limit;
                    r_steps    <= i_head.steps;
                    r_accum    <= i_head.accum_init;
                    r_interval <= i_head.interval;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== dv/segment_dda_step_generator_top_tb.sv =====
module segment_dda_step_generator_top_tb;
    import sdda_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASE_WORDS    = 175;

    typedef struct packed {
        logic               step;
        logic               active;
        logic [LEVEL_W-1:0] level;
        logic               rejected;
        logic               dropped;
    } t_step_res;

    typedef struct {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [SEG_W-1:0]     cfg_val;
        logic                 kind;
        t_seg                 seg;
        logic                 typed;
        t_step_res            want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [SEG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_kind;
    logic [SEG_W-1:0]     i_seg_rate;
    logic [SEG_W-1:0]     i_seg_limit;
    logic [SEG_W-1:0]     i_seg_steps;
    logic [SEG_W-1:0]     i_seg_accum_init;
    logic [SEG_W-1:0]     i_seg_interval;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_step_pulse;
    logic                 o_segment_active;
    logic [LEVEL_W-1:0]   o_queue_level;
    logic                 o_push_rejected;
    logic                 o_segment_dropped;

    // mirror of the block state; run_seg.steps holds the steps left
    t_seg                 fifo_mem [QUEUE_DEPTH];
    int unsigned          fifo_rd;
    int unsigned          fifo_wr;
    int unsigned          fifo_cnt;
    t_seg                 run_seg;
    logic [SEG_W-1:0]     run_accum;
    logic [SEG_W-1:0]     alarm_iv;
    logic [SEG_W-1:0]     countdown;
    logic [SEG_W-1:0]     init_iv;
    logic [SEG_W-1:0]     min_iv;

    t_step_res            pending_results [$];
    t_row                 stim_table [$];
    int                   src_idle_pct   = 0;
    int                   sink_stall_pct = 0;
    logic                 hold_req       = 1'b0;
    int                   err_cnt        = 0;
    int                   n_words        = 0;
    int                   n_results      = 0;
    int                   n_steps        = 0;
    int                   n_rejects      = 0;
    int                   n_drops        = 0;
    int                   idle_cycles    = 0;
    t_step_res            got;
    t_step_res            want;

    segment_dda_step_generator_top i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_kind            (i_kind),
        .i_seg_rate        (i_seg_rate),
        .i_seg_limit       (i_seg_limit),
        .i_seg_steps       (i_seg_steps),
        .i_seg_accum_init  (i_seg_accum_init),
        .i_seg_interval    (i_seg_interval),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_step_pulse      (o_step_pulse),
        .o_segment_active  (o_segment_active),
        .o_queue_level     (o_queue_level),
        .o_push_rejected   (o_push_rejected),
        .o_segment_dropped (o_segment_dropped)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic reset_mirror();
        fifo_rd   = 0;
        fifo_wr   = 0;
        fifo_cnt  = 0;
        run_seg   = '0;
        run_accum = '0;
        init_iv   = INIT_INTERVAL;
        min_iv    = MIN_INTERVAL;
        alarm_iv  = INIT_INTERVAL;
        countdown = INIT_INTERVAL;
    endtask

    function automatic t_step_res predict_step_word(input logic kind, input t_seg seg);
        t_step_res        res;
        t_seg             head;
        logic [SEG_W:0]   sum;
        logic [SEG_W-1:0] acc;
        res = '0;
        if (kind == KIND_PUSH) begin
            if (fifo_cnt >= QUEUE_DEPTH) begin
                res.rejected = 1'b1;
            end else begin
                fifo_mem[fifo_wr] = seg;
                fifo_wr = (fifo_wr + 1) % QUEUE_DEPTH;
                fifo_cnt = fifo_cnt + 1;
            end
        end else if (countdown > 1) begin
            countdown = countdown - 1;
        end else begin
            // alarm: reload with the interval in force before any pop below
            countdown = alarm_iv;
            if (run_seg.steps != 0) begin
                sum = {1'b0, run_accum} + {1'b0, run_seg.rate};
                acc = sum[SEG_W] ? '1 : sum[SEG_W-1:0];
                if (acc >= run_seg.limit) begin
                    res.step = 1'b1;
                    run_seg.steps = run_seg.steps - 1;
                    acc = acc - run_seg.limit;
                end
                run_accum = acc;
            end
            if (run_seg.steps == 0 && fifo_cnt != 0) begin
                head = fifo_mem[fifo_rd];
                fifo_rd = (fifo_rd + 1) % QUEUE_DEPTH;
                fifo_cnt = fifo_cnt - 1;
                if (head.interval < min_iv) begin
                    res.dropped = 1'b1;
                end else begin
                    run_seg   = head;
                    run_accum = head.accum_init;
                    alarm_iv  = head.interval;
                end
            end
        end
        res.active = (run_seg.steps != 0);
        res.level  = fifo_cnt[LEVEL_W-1:0];
        return res;
    endfunction

    function automatic t_seg mk_seg(input logic [SEG_W-1:0] rate, limit, steps, accum, iv);
        return {rate, limit, steps, accum, iv};
    endfunction

    function automatic t_step_res mk_res(input logic step, active, input logic [LEVEL_W-1:0] level,
                                         input logic rejected, dropped);
        return {step, active, level, rejected, dropped};
    endfunction

    function automatic void add_word(input logic kind, input t_seg seg, input logic typed,
                                     input t_step_res want_v);
        t_row row;
        row.is_cfg  = 1'b0;
        row.cfg_idx = '0;
        row.cfg_val = '0;
        row.kind    = kind;
        row.seg     = seg;
        row.typed   = typed;
        row.want    = want_v;
        stim_table.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [SEG_W-1:0] val);
        t_row row;
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        row.kind    = KIND_TICK;
        row.seg     = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        stim_table.push_back(row);
    endfunction

    task automatic build_table();
        add_word(KIND_TICK, '1, 1'b1, mk_res(0, 0, 0, 0, 0));
        add_cfg(CFG_INITIAL_INTERVAL, '1);
        add_cfg(CFG_MIN_INTERVAL, 32'd2);
        add_word(KIND_PUSH, mk_seg(1, 1, 2, 0, 2), 1'b1, mk_res(0, 0, 1, 0, 0));
        // short interval, dropped on pop
        add_word(KIND_PUSH, mk_seg(5, 3, 4, 0, 1), 1'b1, mk_res(0, 0, 2, 0, 0));
        // zero limit
        add_word(KIND_PUSH, mk_seg(0, 0, 2, 0, 3), 1'b1, mk_res(0, 0, 3, 0, 0));
        // accumulator saturates
        add_word(KIND_PUSH, mk_seg('1, 32'hFFFF_FFFE, 2, 32'hFFFF_FFF0, 2), 1'b1,
                 mk_res(0, 0, 4, 0, 0));
        add_word(KIND_PUSH, '0, 1'b1, mk_res(0, 0, 5, 0, 0));
        add_word(KIND_PUSH, mk_seg(7, 10, 0, 9, 2), 1'b1, mk_res(0, 0, 6, 0, 0));
        for (int k = 7; k <= QUEUE_DEPTH; k++)
            add_word(KIND_PUSH, mk_seg(k, 3, 1, 0, 2), 1'b1, mk_res(0, 0, k, 0, 0));
        // queue full
        add_word(KIND_PUSH, '1, 1'b1, mk_res(0, 0, QUEUE_DEPTH, 1, 0));
        add_word(KIND_TICK, '0, 1'b1, mk_res(0, 0, QUEUE_DEPTH, 0, 0));
        add_cfg(CFG_INITIAL_INTERVAL, 32'd1);
        repeat (8) add_word(KIND_TICK, '0, 1'b0, '0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_INITIAL_INTERVAL) begin
            init_iv   = val;
            alarm_iv  = val;
            countdown = val;
        end else if (idx == CFG_MIN_INTERVAL) begin
            min_iv = val;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send_word(input logic kind, input t_seg seg, input logic typed,
                             input t_step_res want_v);
        t_step_res res;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_kind           <= kind;
        i_seg_rate       <= seg.rate;
        i_seg_limit      <= seg.limit;
        i_seg_steps      <= seg.steps;
        i_seg_accum_init <= seg.accum_init;
        i_seg_interval   <= seg.interval;
        do @(posedge i_clk); while (o_in_stall);
        res = predict_step_word(kind, seg);
        pending_results.push_back(typed ? want_v : res);
        n_words++;
    endtask

    task automatic send_random(input int push_pct, input logic wide_iv);
        t_seg seg;
        logic kind;
        seg  = {$urandom, $urandom, $urandom, $urandom, $urandom};
        kind = ($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_TICK;
        if (kind == KIND_PUSH) begin
            seg.steps    = $urandom_range(4);
            seg.interval = wide_iv ? $urandom_range(32'hFFFF_FFFE, 0) : $urandom_range(6);
            case ($urandom_range(7))
                0, 1, 2: begin
                    // small values, nonzero rate so the segment always finishes
                    seg.rate       = $urandom_range(8, 1);
                    seg.limit      = $urandom_range(8);
                    seg.accum_init = $urandom_range(8);
                end
                3: seg.limit = '0;
                // large rate: a step at least every second alarm
                default: seg.rate[SEG_W-1] = 1'b1;
            endcase
        end
        send_word(kind, seg, 1'b0, '0);
    endtask

    task automatic run_phase(input logic [SEG_W-1:0] init_v, min_v, input int src_pct, sink_pct,
                             push_pct, input logic wide_iv, squeeze);
        wait_drained();
        write_reg(CFG_INITIAL_INTERVAL, init_v);
        write_reg(CFG_MIN_INTERVAL, min_v);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        if (squeeze)
            hold_req = 1'b1;
        repeat (PHASE_WORDS) send_random(push_pct, wide_iv);
        // empty the queue so no wide interval is left for later phases
        if (wide_iv)
            while (fifo_cnt != 0) send_word(KIND_TICK, '0, 1'b0, '0);
    endtask

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [SEG_W-1:0] got_v, want_v);
        if (got_v !== want_v) begin
            $display("%0t mismatch on %s: expected %0h, got %0h", $time, name, want_v, got_v);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_step_pulse, o_segment_active, o_queue_level, o_push_rejected,
                   o_segment_dropped};
            n_results++;
            n_steps   += got.step;
            n_rejects += got.rejected;
            n_drops   += got.dropped;
            if (pending_results.size() == 0) begin
                $display("%0t result word with nothing expected: %h", $time, got);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                check_field("step_pulse", got.step, want.step);
                check_field("segment_active", got.active, want.active);
                check_field("queue_level", got.level, want.level);
                check_field("push_rejected", got.rejected, want.rejected);
                check_field("segment_dropped", got.dropped, want.dropped);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t no word moved for %0d cycles", $time, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_row row;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_kind           = KIND_TICK;
        i_seg_rate       = '0;
        i_seg_limit      = '0;
        i_seg_steps      = '0;
        i_seg_accum_init = '0;
        i_seg_interval   = '0;
        reset_mirror();
        build_table();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[i]) begin
            row = stim_table[i];
            if (row.is_cfg) begin
                wait_drained();
                write_reg(row.cfg_idx, row.cfg_val);
            end else begin
                send_word(row.kind, row.seg, row.typed, row.want);
            end
        end

        run_phase(32'd1, 32'd0, 0, 0, 25, 1'b0, 1'b0);
        run_phase(32'd3, 32'd2, 64, 0, 30, 1'b0, 1'b0);
        // every popped segment is dropped here
        run_phase(32'd2, '1, 0, 64, 20, 1'b1, 1'b0);
        run_phase(32'd1, 32'd1, 17, 17, 25, 1'b0, 1'b0);
        // long output hold-off while the input keeps pushing
        run_phase(32'd4, 32'd3, 0, 0, 40, 1'b0, 1'b1);
        wait_drained();

        $display("directed table plus five random phases: %0d words in, %0d results checked",
                 n_words, n_results);
        $display("seen: %0d step pulses, %0d rejected pushes, %0d dropped segments; %0d errors",
                 n_steps, n_rejects, n_drops, err_cnt);
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sdda_pkg.sv
rtl/sdda_fifo.sv
rtl/sdda_core.sv
rtl/segment_dda_step_generator_top.sv
dv/segment_dda_step_generator_top_tb.sv
